@@ rtl/assert_macros.svh @@
// assertion macros for the speed frame parser rtl
// no dependencies; taken in by files that check their own logic
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTHESIS
// clocked check, held off while reset is high
`define SFP_ASSERT(label, clk, rst, prop) \
  label: assert property (@(posedge clk) disable iff (rst) prop) \
    else $error("sfp assertion failed");
// clocked check that also holds during reset
`define SFP_ASSERT_ALWAYS(label, clk, prop) \
  label: assert property (@(posedge clk) prop) \
    else $error("sfp assertion failed");
`else
`define SFP_ASSERT(label, clk, rst, prop)
`define SFP_ASSERT_ALWAYS(label, clk, prop)
`endif

`endif

@@ rtl/sfp_pkg.sv @@
// shared types, constants and the crc-8 update for the speed frame parser
// no dependencies
`default_nettype none

package sfp_pkg;

  localparam int LINE_BYTES_DEF = 256;
  localparam int QUEUE_DEPTH    = 2;
  localparam int PAYLOAD_DEPTH  = 7;
  localparam int PAY_IDX_W      = $clog2(PAYLOAD_DEPTH);

  localparam logic [7:0] CRC_POLY    = 8'h8C;
  localparam logic [7:0] HEAD_FIRST  = 8'h55;
  localparam logic [7:0] HEAD_SECOND = 8'hAA;
  localparam logic [7:0] CHAR_CR     = 8'h0D;
  localparam logic [7:0] CHAR_LF     = 8'h0A;
  localparam logic [7:0] PAY_START   = 8'd3;
  localparam logic [7:0] POS_MAX     = 8'd255;

  typedef enum logic [1:0] {
    ST_OK     = 2'd0,
    ST_HEADER = 2'd1,
    ST_CRC    = 2'd2,
    ST_SHORT  = 2'd3
  } status_t;

  // one classified word handed from front to back
  typedef struct packed {
    logic [7:0]           data;
    logic                 crc_en;
    logic                 check_en;
    logic                 hdr_bad;
    logic                 pay_en;
    logic [PAY_IDX_W-1:0] pay_idx;
    logic                 close;
  } byte_rec_t;

  typedef struct packed {
    logic full;
    logic empty;
  } queue_stat_t;

  // reflected crc-8, lsb first
  function automatic logic [7:0] crc8_absorb(input logic [7:0] crc, input logic [7:0] b);
    logic [7:0] c;
    c = crc ^ b;
    for (int k = 0; k < 8; k++) begin
      if (c[0]) begin
        c = (c >> 1) ^ CRC_POLY;
      end else begin
        c = c >> 1;
      end
    end
    return c;
  endfunction

endpackage

`default_nettype wire

@@ rtl/sfp_if.sv @@
// valid/ready channel interfaces: received words in, frame results out
// depends on nothing but the standard logic type
`default_nettype none

interface sfp_byte_if;
  logic       valid;
  logic       ready;
  logic [7:0] rx_byte;
  modport source (output valid, output rx_byte, input ready);
  modport sink (input valid, input rx_byte, output ready);
endinterface

interface sfp_result_if;
  logic               valid;
  logic               ready;
  logic        [1:0]  status;
  logic signed [15:0] value_first;
  logic signed [15:0] value_second;
  logic signed [15:0] value_third;
  logic        [7:0]  control_flag;
  modport source (output valid, output status, output value_first, output value_second,
                  output value_third, output control_flag, input ready);
  modport sink (input valid, input status, input value_first, input value_second,
                input value_third, input control_flag, output ready);
endinterface

`default_nettype wire

@@ rtl/sfp_front.sv @@
// front end: accepts words, tracks line position, length and cr lf, classifies each word
// depends on sfp_pkg and sfp_byte_if
`default_nettype none

module sfp_front #(
  parameter int LINE_BYTES = sfp_pkg::LINE_BYTES_DEF
) (
  input  wire logic         clk,
  input  wire logic         rst,
  sfp_byte_if.sink          rx,
  output sfp_pkg::byte_rec_t rec,
  output logic              push,
  input  wire logic         push_ready
);

  localparam logic [8:0] ABSORB_LIMIT = (LINE_BYTES < 255) ? 9'(LINE_BYTES) : 9'd255;
  localparam logic [7:0] PAY_START = sfp_pkg::PAY_START;

  logic [7:0] byte_position, byte_position_next;
  logic [7:0] frame_length, frame_length_next;
  logic       last_was_cr, last_was_cr_next;

  logic       absorb;
  logic [7:0] len_eff;
  logic [8:0] check_pos;
  logic       crc_en;

  assign rx.ready = push_ready;
  assign push     = rx.valid && push_ready;

  always_comb begin
    absorb    = {1'b0, byte_position} < ABSORB_LIMIT;
    len_eff   = (byte_position == 8'd2) ? rx.rx_byte : frame_length;
    check_pos = 9'd3 + {1'b0, len_eff};
    crc_en    = absorb && ((byte_position < PAY_START) || ({1'b0, byte_position} < check_pos));

    rec.data     = rx.rx_byte;
    rec.crc_en   = crc_en;
    rec.check_en = absorb && !crc_en && ({1'b0, byte_position} == check_pos);
    rec.hdr_bad  = absorb && (((byte_position == 8'd0) && (rx.rx_byte != sfp_pkg::HEAD_FIRST)) ||
                              ((byte_position == 8'd1) && (rx.rx_byte != sfp_pkg::HEAD_SECOND)));
    rec.pay_en   = absorb && (byte_position >= PAY_START) &&
                   (byte_position < PAY_START + 8'(sfp_pkg::PAYLOAD_DEPTH));
    rec.pay_idx  = sfp_pkg::PAY_IDX_W'(byte_position - PAY_START);
    rec.close    = (rx.rx_byte == sfp_pkg::CHAR_LF) && last_was_cr;
  end

  always_comb begin
    byte_position_next = byte_position;
    frame_length_next  = frame_length;
    last_was_cr_next   = last_was_cr;
    if (push) begin
      if (rec.close) begin
        byte_position_next = '0;
        frame_length_next  = '0;
        last_was_cr_next   = 1'b0;
      end else begin
        if (byte_position != sfp_pkg::POS_MAX) begin
          byte_position_next = byte_position + 8'd1;
        end
        if (absorb && (byte_position == 8'd2)) begin
          frame_length_next = rx.rx_byte;
        end
        last_was_cr_next = (rx.rx_byte == sfp_pkg::CHAR_CR);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      byte_position <= '0;
      frame_length  <= '0;
      last_was_cr   <= 1'b0;
    end else begin
      byte_position <= byte_position_next;
      frame_length  <= frame_length_next;
      last_was_cr   <= last_was_cr_next;
    end
  end

endmodule

`default_nettype wire

@@ rtl/sfp_queue.sv @@
// short queue of classified words between front and back
// depends on sfp_pkg
`default_nettype none

module sfp_queue (
  input  wire logic               clk,
  input  wire logic               rst,
  input  wire logic               push,
  input  wire sfp_pkg::byte_rec_t push_rec,
  input  wire logic               pop,
  output sfp_pkg::byte_rec_t      head,
  output sfp_pkg::queue_stat_t    stat
);

  localparam int DEPTH = sfp_pkg::QUEUE_DEPTH;
  localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W = $clog2(DEPTH + 1);

  sfp_pkg::byte_rec_t entries [DEPTH];
  logic [PTR_W-1:0]   wr_ptr, rd_ptr;
  logic [CNT_W-1:0]   count;

  function automatic logic [PTR_W-1:0] ptr_inc(input logic [PTR_W-1:0] p);
    return (p == PTR_W'(DEPTH - 1)) ? '0 : p + PTR_W'(1);
  endfunction

  assign head       = entries[rd_ptr];
  assign stat.full  = (count == CNT_W'(DEPTH));
  assign stat.empty = (count == '0);

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= ptr_inc(wr_ptr);
      end
      if (pop) begin
        rd_ptr <= ptr_inc(rd_ptr);
      end
      if (push && !pop) begin
        count <= count + CNT_W'(1);
      end else if (pop && !push) begin
        count <= count - CNT_W'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      entries[wr_ptr] <= push_rec;
    end
  end

endmodule

`default_nettype wire

@@ rtl/sfp_back.sv @@
// back end: crc, header and payload capture, status decision and result register
// depends on sfp_pkg and sfp_result_if
`default_nettype none

module sfp_back (
  input  wire logic               clk,
  input  wire logic               rst,
  input  wire sfp_pkg::byte_rec_t head,
  input  wire logic               head_valid,
  output logic                    pop,
  output logic                    load,
  sfp_result_if.source            frame
);

  localparam int PD = sfp_pkg::PAYLOAD_DEPTH;

  logic [7:0] running_crc;
  logic       header_good;
  logic [7:0] check_byte;
  logic       check_seen;
  logic [7:0] payload_bytes [PD];

  logic [7:0] crc_next;
  logic       header_next;
  logic [7:0] check_next;
  logic       seen_next;
  logic [7:0] pay_next [PD];
  sfp_pkg::status_t st;
  logic       out_free;

  logic               out_valid;
  logic [1:0]         out_status;
  logic signed [15:0] out_v1, out_v2, out_v3;
  logic [7:0]         out_flag;

  assign out_free = !out_valid || frame.ready;
  assign pop      = head_valid && (!head.close || out_free);
  assign load     = pop && head.close;

  always_comb begin
    crc_next    = head.crc_en ? sfp_pkg::crc8_absorb(running_crc, head.data) : running_crc;
    header_next = header_good && !head.hdr_bad;
    check_next  = head.check_en ? head.data : check_byte;
    seen_next   = check_seen || head.check_en;
    for (int i = 0; i < PD; i++) begin
      pay_next[i] = (head.pay_en && (head.pay_idx == sfp_pkg::PAY_IDX_W'(i))) ?
                    head.data : payload_bytes[i];
    end
    // header error wins, then short frame, then checksum
    if (!header_next) begin
      st = sfp_pkg::ST_HEADER;
    end else if (!seen_next) begin
      st = sfp_pkg::ST_SHORT;
    end else if (crc_next != check_next) begin
      st = sfp_pkg::ST_CRC;
    end else begin
      st = sfp_pkg::ST_OK;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      running_crc <= '0;
      header_good <= 1'b1;
      check_byte  <= '0;
      check_seen  <= 1'b0;
      for (int i = 0; i < PD; i++) begin
        payload_bytes[i] <= '0;
      end
    end else if (pop) begin
      if (head.close) begin
        running_crc <= '0;
        header_good <= 1'b1;
        check_byte  <= '0;
        check_seen  <= 1'b0;
        for (int i = 0; i < PD; i++) begin
          payload_bytes[i] <= '0;
        end
      end else begin
        running_crc <= crc_next;
        header_good <= header_next;
        check_byte  <= check_next;
        check_seen  <= seen_next;
        for (int i = 0; i < PD; i++) begin
          payload_bytes[i] <= pay_next[i];
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (load) begin
      out_valid <= 1'b1;
    end else if (frame.ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      out_status <= st;
      if (st == sfp_pkg::ST_OK) begin
        out_v1   <= {pay_next[1], pay_next[0]};
        out_v2   <= {pay_next[3], pay_next[2]};
        out_v3   <= {pay_next[5], pay_next[4]};
        out_flag <= pay_next[6];
      end else begin
        out_v1   <= '0;
        out_v2   <= '0;
        out_v3   <= '0;
        out_flag <= '0;
      end
    end
  end

  assign frame.valid        = out_valid;
  assign frame.status       = out_status;
  assign frame.value_first  = out_v1;
  assign frame.value_second = out_v2;
  assign frame.value_third  = out_v3;
  assign frame.control_flag = out_flag;

endmodule

`default_nettype wire

@@ rtl/speed_frame_parser.sv @@
// speed_frame_parser top level: front classifier, word queue, back end with result register
// depends on sfp_pkg, sfp_if, sfp_front, sfp_queue, sfp_back, assert_macros.svh
//
//   channel  dir  payload                                        moves
//   rx       in   rx_byte[7:0]                                   one word per line byte
//   frame    out  status, value_first/second/third, control_flag one word per closed line
//
// flow: one word accepted every cycle while the queue is not full; the front tags a word in
//   its cycle of acceptance and the back applies it once it leaves the queue, and a result
//   appears the cycle after the back takes the closing lf
// the crc-8 update of a word is one combinational step in the back end
// reset: synchronous, clears line position, length, crc, flags, payload and queue
// stalls: a held result blocks only a closing word; the two-entry queue lets the
//   front keep taking words, and rx.ready falls only when the queue is full
`default_nettype none

`include "assert_macros.svh"

module speed_frame_parser #(
  parameter int LINE_BYTES = sfp_pkg::LINE_BYTES_DEF
) (
  input  wire logic    clk,
  input  wire logic    rst,
  sfp_byte_if.sink     rx,
  sfp_result_if.source frame
);

  sfp_pkg::byte_rec_t   push_rec;
  sfp_pkg::byte_rec_t   head;
  sfp_pkg::queue_stat_t q_stat;
  logic                 push;
  logic                 pop;
  logic                 load;

  // front: position, length and cr lf tracking, word classification
  sfp_front #(
    .LINE_BYTES (LINE_BYTES)
  ) u_front (
    .clk        (clk),
    .rst        (rst),
    .rx         (rx),
    .rec        (push_rec),
    .push       (push),
    .push_ready (!q_stat.full)
  );

  // decoupling queue
  sfp_queue u_queue (
    .clk      (clk),
    .rst      (rst),
    .push     (push),
    .push_rec (push_rec),
    .pop      (pop),
    .head     (head),
    .stat     (q_stat)
  );

  // back: crc and capture, status decision, output register
  sfp_back u_back (
    .clk        (clk),
    .rst        (rst),
    .head       (head),
    .head_valid (!q_stat.empty),
    .pop        (pop),
    .load       (load),
    .frame      (frame)
  );

  // queue can never be full and empty at once
  `SFP_ASSERT(a_queue_stat, clk, rst, !(q_stat.full && q_stat.empty))
  // a result only shows up after the back took a closing word
  `SFP_ASSERT(a_result_from_close, clk, rst, $rose(frame.valid) |-> $past(load))
  // a pushed word is still queued in the cycle after its push
  `SFP_ASSERT(a_push_lands, clk, rst, push |=> !q_stat.empty)

endmodule

`default_nettype wire

@@ tb/sv/speed_frame_parser_tb.sv @@
// testbench for speed_frame_parser: byte stream in, one checked result per closed line
// depends on sfp_pkg (constants, status_t), sfp_if (channel interfaces) and speed_frame_parser from the rtl
// self-checking: a line predictor runs beside the block and compares every result word
module speed_frame_parser_tb;
  timeunit 1ns;
  timeprecision 1ps;

  import sfp_pkg::*;

  // bytes at or past this position are not absorbed, only watched for cr lf
  localparam int LINE_LIMIT   = (LINE_BYTES_DEF < 255) ? LINE_BYTES_DEF : 255;
  localparam int RANDOM_WORDS = 150;
  localparam int CALM_WORDS   = 50;        // tail of the random part with no idling
  localparam int TAIL_CYCLES  = 16;
  localparam int CYCLE_LIMIT  = 300000;

  typedef enum int {
    CRC_GOOD,
    CRC_BAD,
    CRC_NONE
  } crc_kind_t;

  typedef logic [7:0] byte_q_t[$];

  typedef struct {
    status_t            status;
    logic signed [15:0] first;
    logic signed [15:0] second;
    logic signed [15:0] third;
    logic        [7:0]  flag;
  } frame_result_t;

  logic clk;
  logic rst;

  sfp_byte_if   rx_if ();
  sfp_result_if frame_if ();

  speed_frame_parser DUT (
    .clk  (clk),
    .rst  (rst),
    .rx   (rx_if),
    .frame(frame_if)
  );

  // results the predictor has worked out, oldest first
  frame_result_t expected_frames[$];

  int  mismatches      = 0;
  int  words_sent      = 0;
  int  results_checked = 0;
  int  status_seen[4]  = '{0, 0, 0, 0};
  int  cycles          = 0;
  int  ready_hold      = 0;
  bit  idle_on         = 1'b1;

  // predictor copy of the line state
  logic [7:0] line_pos;
  logic [7:0] line_crc;
  logic [7:0] line_len;
  logic [7:0] line_check;
  logic [7:0] line_pay [PAYLOAD_DEPTH];
  bit         line_hdr_ok;
  bit         line_check_seen;
  bit         line_cr;

  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  // reflected crc-8, one message bit at a time
  function automatic logic [7:0] crc_step(logic [7:0] c, logic [7:0] b);
    logic fb;
    for (int i = 0; i < 8; i++) begin
      fb = c[0] ^ b[i];
      c  = {1'b0, c[7:1]};
      if (fb) begin
        c = c ^ CRC_POLY;
      end
    end
    return c;
  endfunction

  function automatic void line_clear();
    line_pos        = '0;
    line_crc        = '0;
    line_len        = '0;
    line_check      = '0;
    line_hdr_ok     = 1'b1;
    line_check_seen = 1'b0;
    line_cr         = 1'b0;
    foreach (line_pay[i]) line_pay[i] = '0;
  endfunction

  // advance the line state by one accepted word; a closing lf queues a result
  function automatic void predict_word(logic [7:0] b);
    int            p;
    int            check_at;
    frame_result_t r;
    p        = int'(line_pos);
    check_at = int'(PAY_START) + int'(line_len);
    if (p < LINE_LIMIT) begin
      if (p == 0 && b != HEAD_FIRST) line_hdr_ok = 1'b0;
      if (p == 1 && b != HEAD_SECOND) line_hdr_ok = 1'b0;
      if (p == 2) begin
        line_len = b;
        check_at = int'(PAY_START) + int'(b);
      end
      // header and length always feed the crc, then the body up to the check byte
      if (p < int'(PAY_START) || p < check_at) begin
        line_crc = crc_step(line_crc, b);
      end else if (p == check_at) begin
        line_check      = b;
        line_check_seen = 1'b1;
      end
      // payload slots take whatever sits at positions 3..9, check byte and cr lf too
      if (p >= int'(PAY_START) && p < int'(PAY_START) + PAYLOAD_DEPTH) begin
        line_pay[p - int'(PAY_START)] = b;
      end
    end
    if (line_pos != POS_MAX) line_pos = line_pos + 8'd1;

    if (!(b == CHAR_LF && line_cr)) begin
      line_cr = (b == CHAR_CR);
      return;
    end

    // line closed: header beats short, short beats checksum
    r.first  = '0;
    r.second = '0;
    r.third  = '0;
    r.flag   = '0;
    if (!line_hdr_ok) begin
      r.status = ST_HEADER;
    end else if (!line_check_seen) begin
      r.status = ST_SHORT;
    end else if (line_crc != line_check) begin
      r.status = ST_CRC;
    end else begin
      r.status = ST_OK;
      r.first  = {line_pay[1], line_pay[0]};
      r.second = {line_pay[3], line_pay[2]};
      r.third  = {line_pay[5], line_pay[4]};
      r.flag   = line_pay[6];
    end
    expected_frames.push_back(r);
    line_clear();
  endfunction

  task automatic report_mismatch(input string what);
    $display("mismatch at cycle %0d: %s", cycles, what);
    mismatches++;
  endtask

  // one word on the rx channel; called at a falling edge, returns at a falling edge
  task automatic send_word(input logic [7:0] b);
    int gap;
    if (idle_on && $urandom_range(0, 7) == 0) begin
      gap = $urandom_range(1, 19);
      rx_if.valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    rx_if.valid   <= 1'b1;
    rx_if.rx_byte <= b;
    do @(posedge clk); while (rx_if.ready !== 1'b1);
    predict_word(b);
    words_sent++;
    @(negedge clk);
  endtask

  // header, length, body, optional check byte, then cr lf
  task automatic send_frame(input logic [7:0] head_a, input logic [7:0] head_b,
                            input logic [7:0] len, input byte_q_t body,
                            input crc_kind_t kind);
    logic [7:0] c;
    c = crc_step(crc_step(crc_step(8'h00, head_a), head_b), len);
    send_word(head_a);
    send_word(head_b);
    send_word(len);
    foreach (body[i]) begin
      c = crc_step(c, body[i]);
      send_word(body[i]);
    end
    case (kind)
      CRC_GOOD: begin
        send_word(c);
      end
      CRC_BAD: begin
        send_word(c ^ 8'($urandom_range(1, 255)));
      end
      default: begin
      end
    endcase
    send_word(CHAR_CR);
    send_word(CHAR_LF);
  endtask

  // random body with no cr lf pair inside, so the line survives to its check byte
  function automatic byte_q_t make_body(int n);
    byte_q_t    q;
    logic [7:0] b;
    for (int i = 0; i < n; i++) begin
      b = 8'($urandom);
      if (q.size() > 0 && q[$] == CHAR_CR && b == CHAR_LF) b = 8'h0B;
      q.push_back(b);
    end
    return q;
  endfunction

  // single body byte that makes a length-one frame's crc land on the wanted value
  function automatic logic [7:0] body_byte_for_crc(logic [7:0] want);
    logic [7:0] c0;
    c0 = crc_step(crc_step(crc_step(8'h00, HEAD_FIRST), HEAD_SECOND), 8'd1);
    for (int d = 0; d < 256; d++) begin
      if (crc_step(c0, 8'(d)) == want) return 8'(d);
    end
    return 8'h00;
  endfunction

  task automatic test_good_frames();
    // value extremes: -32768, 32767, 1 and a full flag byte
    send_frame(HEAD_FIRST, HEAD_SECOND, 8'd7,
               '{8'h00, 8'h80, 8'hFF, 8'h7F, 8'h01, 8'h00, 8'hFF}, CRC_GOOD);
    // zero length: check byte, cr and lf fall into the payload slots
    send_frame(HEAD_FIRST, HEAD_SECOND, 8'd0, '{}, CRC_GOOD);
  endtask

  task automatic test_header_errors();
    // empty line
    send_word(CHAR_CR);
    send_word(CHAR_LF);
    // swapped header bytes
    send_frame(HEAD_SECOND, HEAD_FIRST, 8'd0, '{}, CRC_GOOD);
    // bad header and short at once: header wins
    send_frame(8'h00, HEAD_SECOND, 8'd5, '{}, CRC_NONE);
  endtask

  task automatic test_crc_errors();
    send_frame(HEAD_FIRST, HEAD_SECOND, 8'd7, make_body(7), CRC_BAD);
  endtask

  task automatic test_short_frames();
    // line ends before the check byte; the crc mismatch never counts
    send_frame(HEAD_FIRST, HEAD_SECOND, 8'd8, '{8'h11, 8'h22}, CRC_NONE);
  endtask

  task automatic test_check_byte_cr_lf();
    send_frame(HEAD_FIRST, HEAD_SECOND, 8'd1, '{body_byte_for_crc(CHAR_CR)}, CRC_GOOD);
    send_frame(HEAD_FIRST, HEAD_SECOND, 8'd1, '{body_byte_for_crc(CHAR_LF)}, CRC_GOOD);
  endtask

  task automatic test_line_breaks();
    // cr not followed by lf is an ordinary byte
    send_frame(HEAD_FIRST, HEAD_SECOND, 8'd3, '{CHAR_CR, 8'h41, CHAR_CR}, CRC_GOOD);
    // a lone lf opens the next line with a bad header
    send_word(CHAR_LF);
    send_frame(HEAD_FIRST, HEAD_SECOND, 8'd0, '{}, CRC_GOOD);
    // cr lf inside the body closes the line early; the rest forms its own line
    send_frame(HEAD_FIRST, HEAD_SECOND, 8'd6,
               '{8'h01, CHAR_CR, CHAR_LF, 8'h02, 8'h03, 8'h04}, CRC_GOOD);
  endtask

  task automatic test_long_line();
    // check byte at position 254, the last one absorbed
    send_frame(HEAD_FIRST, HEAD_SECOND, 8'd251, make_body(251), CRC_GOOD);
    // check byte beyond the absorb limit, position counter saturates
    send_frame(HEAD_FIRST, HEAD_SECOND, 8'd255, make_body(262), CRC_NONE);
  endtask

  task automatic test_random_traffic();
    int         goal;
    int         pick;
    int         n;
    logic [7:0] bad;
    goal = words_sent + RANDOM_WORDS;
    while (words_sent < goal) begin
      // idling comes in stretches, none at all near the end
      idle_on = (words_sent < goal - CALM_WORDS) && ($urandom_range(0, 3) != 0);
      pick    = $urandom_range(0, 99);
      if (pick < 55) begin
        n = $urandom_range(7, 14);
        send_frame(HEAD_FIRST, HEAD_SECOND, 8'(n), make_body(n), CRC_GOOD);
      end else if (pick < 65) begin
        n = $urandom_range(0, 6);
        send_frame(HEAD_FIRST, HEAD_SECOND, 8'(n), make_body(n), CRC_GOOD);
      end else if (pick < 73) begin
        n = $urandom_range(0, 14);
        send_frame(HEAD_FIRST, HEAD_SECOND, 8'(n), make_body(n), CRC_BAD);
      end else if (pick < 80) begin
        n   = $urandom_range(0, 10);
        bad = 8'($urandom);
        if ($urandom_range(0, 1) == 0) begin
          if (bad == HEAD_FIRST) bad = bad ^ 8'h01;
          send_frame(bad, HEAD_SECOND, 8'(n), make_body(n), CRC_GOOD);
        end else begin
          if (bad == HEAD_SECOND) bad = bad ^ 8'h01;
          send_frame(HEAD_FIRST, bad, 8'(n), make_body(n), CRC_GOOD);
        end
      end else if (pick < 87) begin
        n = $urandom_range(8, 20);
        send_frame(HEAD_FIRST, HEAD_SECOND, 8'(n), make_body($urandom_range(0, n - 1)),
                   CRC_NONE);
      end else if (pick < 95) begin
        // raw noise, closed
        n = $urandom_range(1, 12);
        repeat (n) send_word(8'($urandom));
        send_word(CHAR_CR);
        send_word(CHAR_LF);
      end else begin
        // raw noise left open, spoils the next frame's header
        n = $urandom_range(1, 6);
        repeat (n) send_word(8'($urandom));
      end
    end
  endtask

  // result side: random stall bursts while idling is on
  always @(negedge clk) begin
    if (ready_hold > 0) begin
      frame_if.ready <= 1'b0;
      ready_hold--;
    end else if (idle_on && $urandom_range(0, 15) == 0) begin
      frame_if.ready <= 1'b0;
      ready_hold = $urandom_range(0, 18);
    end else begin
      frame_if.ready <= 1'b1;
    end
  end

  // compare every accepted result word with the oldest prediction
  always @(posedge clk) begin : check_result
    frame_result_t want;
    if (!rst && frame_if.valid === 1'b1 && frame_if.ready === 1'b1) begin
      if (expected_frames.size() == 0) begin
        report_mismatch($sformatf("result word with no closed line pending, status %0d",
                                  frame_if.status));
      end else begin
        want = expected_frames.pop_front();
        results_checked++;
        status_seen[int'(want.status)]++;
        if (frame_if.status !== want.status)
          report_mismatch($sformatf("frame %0d status %0d, want %0d", results_checked,
                                    frame_if.status, want.status));
        if (frame_if.value_first !== want.first)
          report_mismatch($sformatf("frame %0d value_first %0d, want %0d", results_checked,
                                    frame_if.value_first, want.first));
        if (frame_if.value_second !== want.second)
          report_mismatch($sformatf("frame %0d value_second %0d, want %0d", results_checked,
                                    frame_if.value_second, want.second));
        if (frame_if.value_third !== want.third)
          report_mismatch($sformatf("frame %0d value_third %0d, want %0d", results_checked,
                                    frame_if.value_third, want.third));
        if (frame_if.control_flag !== want.flag)
          report_mismatch($sformatf("frame %0d control_flag %0h, want %0h", results_checked,
                                    frame_if.control_flag, want.flag));
      end
    end
  end

  // watchdog
  always @(posedge clk) begin
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("timeout with %0d results still pending", expected_frames.size());
      $display("[FAIL] regression broken");
      $finish;
    end
  end

  initial begin
    rst            = 1'b1;
    rx_if.valid    = 1'b0;
    rx_if.rx_byte  = 8'h00;
    line_clear();
    repeat (10) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);

    test_good_frames();
    test_header_errors();
    test_crc_errors();
    test_short_frames();
    test_check_byte_cr_lf();
    test_line_breaks();
    test_long_line();
    test_random_traffic();

    // stop sending, let the last results drain
    rx_if.valid <= 1'b0;
    idle_on = 1'b0;
    while (expected_frames.size() != 0) @(posedge clk);
    repeat (TAIL_CYCLES) @(posedge clk);

    $display("sent %0d bytes, checked %0d frame results", words_sent, results_checked);
    $display("statuses seen: ok %0d, header %0d, checksum %0d, short %0d",
             status_seen[ST_OK], status_seen[ST_HEADER], status_seen[ST_CRC],
             status_seen[ST_SHORT]);
    if (mismatches == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

endmodule

@@ speed_frame_parser.f @@
+incdir+rtl
rtl/sfp_pkg.sv
rtl/sfp_if.sv
rtl/sfp_front.sv
rtl/sfp_queue.sv
rtl/sfp_back.sv
rtl/speed_frame_parser.sv
tb/sv/speed_frame_parser_tb.sv
